// ----- hw/rtl/dvst_pkg.sv -----
// ----------------------------------------------------------------------------
// dvst_pkg
// Shared types and constants for the distinct value set table.
// ----------------------------------------------------------------------------
package dvst_pkg;

	localparam int CAPACITY = 16;
	localparam int VALUE_W  = 32;
	localparam int KIND_W   = 2;
	localparam int COUNT_W  = $clog2(CAPACITY + 1);
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

	typedef logic [CAPACITY-1:0][VALUE_W-1:0] entry_arr_t;

	// lookup outcome for the request in the input register
	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] slot;
	} match_t;

	// request handed to the table for this cycle
	typedef struct packed {
		logic               valid;
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
		logic               hit;
		logic [IDX_W-1:0]   slot;
	} dvst_op_t;

	// what the table reports back for the result
	typedef struct packed {
		logic               dropped;
		logic [COUNT_W-1:0] count_next;
	} table_status_t;

endpackage

// ----- hw/rtl/dvst_match.sv -----
// ----------------------------------------------------------------------------
// dvst_match
// Parallel compare of one value against every occupied table slot.
// ----------------------------------------------------------------------------
module dvst_match import dvst_pkg::*; (
	input  entry_arr_t         entries,
	input  logic [COUNT_W-1:0] count,
	input  logic [VALUE_W-1:0] value,
	output match_t             match
);

	// scan downwards so the lowest matching slot wins
	always_comb begin
		match.hit  = 1'b0;
		match.slot = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if ((COUNT_W'(i) < count) && (entries[i] == value)) begin
				match.hit  = 1'b1;
				match.slot = IDX_W'(i);
			end
		end
	end

endmodule

// ----- hw/rtl/dvst_table.sv -----
// ----------------------------------------------------------------------------
// dvst_table
// Entry registers and occupancy count, with insert-at-tail and swap-remove.
// ----------------------------------------------------------------------------
module dvst_table import dvst_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dvst_op_t           op,
	output entry_arr_t         entries,
	output logic [COUNT_W-1:0] count,
	output table_status_t      status
);

	entry_arr_t         entries_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] last;
	logic               is_full;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_idx;
	logic [VALUE_W-1:0] wr_data;
	logic [COUNT_W-1:0] count_next;
	logic               dropped;

	assign last    = count_q - COUNT_W'(1);
	assign is_full = (count_q == COUNT_W'(CAPACITY));

	always_comb begin
		wr_en      = 1'b0;
		wr_idx     = count_q[IDX_W-1:0];
		wr_data    = op.value;
		count_next = count_q;
		dropped    = 1'b0;
		if (op.valid) begin
			unique case (op.kind)
				KIND_INSERT: begin
					if (!op.hit) begin
						if (is_full) begin
							dropped = 1'b1;
						end else begin
							wr_en      = 1'b1;
							count_next = count_q + COUNT_W'(1);
						end
					end
				end
				KIND_REMOVE: begin
					// move the tail entry into the freed slot
					if (op.hit) begin
						wr_en      = 1'b1;
						wr_idx     = op.slot;
						wr_data    = entries_q[last[IDX_W-1:0]];
						count_next = last;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entries_q[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	assign entries           = entries_q;
	assign count             = count_q;
	assign status.dropped    = dropped;
	assign status.count_next = count_next;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(CAPACITY))
		else $error("occupancy count beyond capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(op.valid && op.kind == KIND_INSERT && !op.hit && !is_full)
		|=> count_q == $past(count_q) + COUNT_W'(1))
		else $error("insert of absent value did not grow the count");

	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(op.valid && op.kind == KIND_REMOVE && op.hit)
		|=> count_q == $past(count_q) - COUNT_W'(1))
		else $error("remove of present value did not shrink the count");
`endif

endmodule

// ----- hw/rtl/distinct_value_set_table_unit.sv -----
// ----------------------------------------------------------------------------
// distinct_value_set_table_unit
// Set of distinct 32-bit values with insert, swap-remove and membership query.
// ----------------------------------------------------------------------------
// One request is accepted every cycle unless the result register is stalled.
// A request waits in the input register, where it is compared against all
// sixteen table slots at once and the table and count are updated; its result
// is then registered in the result register. The compare-and-update loop on
// the table registers closes in that stage, so back-to-back requests always
// see the effect of the one before. Full-table inserts are dropped and flagged.
module distinct_value_set_table_unit import dvst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] value
	input  logic [1:0]  s_axis_tuser,  // [1:0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata   // [0] was_present, [1] dropped_full,
	                                   // [6:2] occupancy, [7] zero
);

	logic                      valid_s1;
	logic [KIND_W-1:0]         kind_s1;
	logic signed [VALUE_W-1:0] value_s1;
	logic                      out_valid_q;
	logic                      was_present_q;
	logic                      dropped_full_q;
	logic [COUNT_W-1:0]        occupancy_q;
	logic                      advance;
	entry_arr_t                entries;
	logic [COUNT_W-1:0]        count;
	match_t                    match;
	dvst_op_t                  op;
	table_status_t             status;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			kind_s1  <= s_axis_tuser;
			value_s1 <= $signed(s_axis_tdata);
		end
	end

	dvst_match u_match (
		.entries (entries),
		.count   (count),
		.value   ($unsigned(value_s1)),
		.match   (match)
	);

	assign op.valid = advance;
	assign op.kind  = kind_s1;
	assign op.value = $unsigned(value_s1);
	assign op.hit   = match.hit;
	assign op.slot  = match.slot;

	dvst_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (op),
		.entries (entries),
		.count   (count),
		.status  (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= advance || (out_valid_q && !m_axis_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			was_present_q  <= match.hit;
			dropped_full_q <= status.dropped;
			occupancy_q    <= status.count_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, occupancy_q, dropped_full_q, was_present_q};

`ifndef SYNTHESIS
	a_drop_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[1])
		|-> (m_axis_tdata[6:2] == COUNT_W'(CAPACITY)) && !m_axis_tdata[0])
		else $error("dropped insert reported without a full table");
`endif

endmodule
